@@ sv/fscan_disk_request_scheduler_assert.svh @@
// assertion macros for the fscan scheduler
// FSCAN_ASSERT checks a property on every clock edge outside reset
// FSCAN_ASSERT_NEVER checks that a condition never holds
`ifndef FSCAN_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define FSCAN_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FSCAN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fscan assertion failed");
`define FSCAN_ASSERT_NEVER(label, clk, rst_n, cond) \
  `FSCAN_ASSERT(label, clk, rst_n, !(cond))
`else
`define FSCAN_ASSERT(label, clk, rst_n, prop)
`define FSCAN_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ sv/fscan_pkg.sv @@
// ----------------------------------------------------------------------------
// fscan_pkg
// shared types, codes and default sizes of the fscan request scheduler
// ----------------------------------------------------------------------------
package fscan_pkg;

  // default sizes
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TrackBitsDef  = 12;
  localparam int unsigned IdBitsDef     = 8;

  // operation codes
  localparam logic OpAdd      = 1'b0;
  localparam logic OpDispatch = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // compare unit decisions for one scanned entry
  typedef struct packed {
    logic take_best;
    logic take_fb;
  } cmp_res_t;

endpackage

@@ sv/fscan_ram.sv @@
// ----------------------------------------------------------------------------
// fscan_ram
// generic single write port memory with one registered read port
// ----------------------------------------------------------------------------
module fscan_ram #(
  parameter int unsigned WIDTH = fscan_pkg::TrackBitsDef + fscan_pkg::IdBitsDef,
  parameter int unsigned DEPTH = fscan_pkg::QueueDepthDef,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fscan_cmp.sv @@
// ----------------------------------------------------------------------------
// fscan_cmp
// shared compare unit: judges one queue entry against the running picks
// ----------------------------------------------------------------------------
module fscan_cmp #(
  parameter int unsigned TRACK_BITS = fscan_pkg::TrackBitsDef
) (
  input  logic                  sweep_up_i,
  input  logic [TRACK_BITS-1:0] track_i,
  input  logic [TRACK_BITS-1:0] head_i,
  input  logic [TRACK_BITS-1:0] best_i,
  input  logic [TRACK_BITS-1:0] fb_i,
  input  logic                  found_i,
  input  logic                  first_i,
  output fscan_pkg::cmp_res_t   res_o
);
  import fscan_pkg::*;

  logic [TRACK_BITS-1:0] key;
  logic [TRACK_BITS-1:0] head_key;
  logic [TRACK_BITS-1:0] best_key;
  logic [TRACK_BITS-1:0] fb_key;

  // down sweep mirrors the up sweep on inverted tracks
  always_comb begin
    key      = sweep_up_i ? track_i : ~track_i;
    head_key = sweep_up_i ? head_i  : ~head_i;
    best_key = sweep_up_i ? best_i  : ~best_i;
    fb_key   = sweep_up_i ? fb_i    : ~fb_i;
  end

  // strict compares keep the oldest entry on ties
  always_comb begin
    res_o.take_best = (key >= head_key) && (!found_i || (key < best_key));
    res_o.take_fb   = first_i || (key > fb_key);
  end

endmodule

@@ sv/fscan_disk_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// fscan_disk_request_scheduler
// fscan disk request scheduler with two request queues and a sweep direction
// ----------------------------------------------------------------------------
// Usage: an input beat on in_valid_i/in_ready_o either adds a request
// (operation 0) to the ready or secondary queue, or dispatches one request
// (operation 1) for the given head track. Every input beat produces exactly
// one result beat on out_valid_o/out_ready_i with the grant, pending flag and
// status. The block takes one item at a time; in_ready_o is high only while
// the sequencer is idle.
// Sequence: an add, or a dispatch with both queues empty, goes straight from
// IDLE to FINISH, which loads the result register and raises out_valid_o.
// A dispatch with ready requests scans the queue through the compare unit
// (SCAN), closes the gap behind the granted entry by moving each later entry
// down by one (SHIFT) and loads the result (FINISH). Entries pass one at a
// time through the single read port of the queue memory.
// Reset empties both queues and sets the sweep direction to up; no clearing
// pass is run. A stalled receiver holds the result register; the next item
// is still accepted, but its result waits until the register drains.
// ----------------------------------------------------------------------------
module fscan_disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH = fscan_pkg::QueueDepthDef,
  parameter int unsigned TRACK_BITS  = fscan_pkg::TrackBitsDef,
  parameter int unsigned ID_BITS     = fscan_pkg::IdBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic                  to_secondary_i,
  input  logic [ID_BITS-1:0]    request_id_i,
  input  logic [TRACK_BITS-1:0] track_i,
  input  logic [TRACK_BITS-1:0] head_track_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  granted_o,
  output logic [ID_BITS-1:0]    granted_id_o,
  output logic [TRACK_BITS-1:0] granted_track_o,
  output logic                  pending_o,
  output logic [1:0]            status_o
);
  import fscan_pkg::*;

`include "fscan_disk_request_scheduler_assert.svh"

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntW = ID_BITS + TRACK_BITS;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT,
    FINISH
  } state_e;

  state_e                state_q;
  logic                  rsel_q;
  logic [CntW-1:0]       rcnt_q;
  logic [CntW-1:0]       wcnt_q;
  logic                  sweep_up_q;
  logic [TRACK_BITS-1:0] head_q;
  logic [CntW-1:0]       ridx_q;
  logic [IdxW-1:0]       pidx_q;
  logic                  pvld_q;
  logic                  found_q;
  logic                  first_q;
  logic [IdxW-1:0]       best_idx_q;
  logic [EntW-1:0]       best_ent_q;
  logic [IdxW-1:0]       fb_idx_q;
  logic [EntW-1:0]       fb_ent_q;
  logic                  res_granted_q;
  logic [EntW-1:0]       res_ent_q;
  status_e               res_status_q;
  logic                  out_valid_q;
  logic                  out_granted_q;
  logic [EntW-1:0]       out_ent_q;
  status_e               out_status_q;
  logic                  out_pending_q;

  logic                  ram_we;
  logic                  ram_wbank;
  logic [IdxW-1:0]       ram_waddr;
  logic [EntW-1:0]       ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [EntW-1:0]       rdata0;
  logic [EntW-1:0]       rdata1;
  logic [EntW-1:0]       rdata;
  logic [CntW-1:0]       add_cnt;
  logic [CntW-1:0]       eff_rcnt;
  logic [IdxW-1:0]       pick_idx;
  logic                  accept;
  cmp_res_t              cmp_res;

  assign in_ready_o = (state_q == IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign add_cnt    = to_secondary_i ? wcnt_q : rcnt_q;
  assign eff_rcnt   = (rcnt_q == '0) ? wcnt_q : rcnt_q;
  assign rdata      = rsel_q ? rdata1 : rdata0;
  assign pick_idx   = found_q ? best_idx_q : fb_idx_q;

  // queue memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_wbank = rsel_q;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = ridx_q[IdxW-1:0];
    if (accept && (operation_i == OpAdd)) begin
      ram_wbank = to_secondary_i ? ~rsel_q : rsel_q;
      ram_waddr = add_cnt[IdxW-1:0];
      ram_wdata = {request_id_i, track_i};
      ram_we    = (add_cnt < CntW'(QUEUE_DEPTH));
    end else if ((state_q == SHIFT) && pvld_q) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_q - IdxW'(1);
      ram_wdata = rdata;
    end
  end

  // two banks; the roles of ready and secondary queue swap on a refill
  fscan_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_we && !ram_wbank),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata0)
  );

  fscan_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_we && ram_wbank),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata1)
  );

  // shared compare unit
  fscan_cmp #(
    .TRACK_BITS (TRACK_BITS)
  ) u_cmp (
    .sweep_up_i (sweep_up_q),
    .track_i    (rdata[TRACK_BITS-1:0]),
    .head_i     (head_q),
    .best_i     (best_ent_q[TRACK_BITS-1:0]),
    .fb_i       (fb_ent_q[TRACK_BITS-1:0]),
    .found_i    (found_q),
    .first_i    (first_q),
    .res_o      (cmp_res)
  );

  // sequencer, queue state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= IDLE;
      rsel_q        <= 1'b0;
      rcnt_q        <= '0;
      wcnt_q        <= '0;
      sweep_up_q    <= 1'b1;
      head_q        <= '0;
      ridx_q        <= '0;
      pidx_q        <= '0;
      pvld_q        <= 1'b0;
      found_q       <= 1'b0;
      first_q       <= 1'b1;
      best_idx_q    <= '0;
      best_ent_q    <= '0;
      fb_idx_q      <= '0;
      fb_ent_q      <= '0;
      res_granted_q <= 1'b0;
      res_ent_q     <= '0;
      res_status_q  <= ST_OK;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_ent_q     <= '0;
      out_status_q  <= ST_OK;
      out_pending_q <= 1'b0;
    end else begin
      // result beat taken and no new result loaded behind it
      if (out_valid_q && out_ready_i && (state_q != FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        IDLE: begin
          if (accept) begin
            res_granted_q <= 1'b0;
            res_ent_q     <= '0;
            res_status_q  <= ST_OK;
            ridx_q        <= '0;
            pvld_q        <= 1'b0;
            found_q       <= 1'b0;
            first_q       <= 1'b1;
            head_q        <= head_track_i;
            if (operation_i == OpAdd) begin
              state_q <= FINISH;
              if (add_cnt >= CntW'(QUEUE_DEPTH)) begin
                res_status_q <= ST_FULL;
              end else if (to_secondary_i) begin
                wcnt_q <= wcnt_q + CntW'(1);
              end else begin
                rcnt_q <= rcnt_q + CntW'(1);
              end
            end else begin
              // refill from the secondary queue by swapping banks
              if (rcnt_q == '0) begin
                rsel_q     <= ~rsel_q;
                rcnt_q     <= wcnt_q;
                wcnt_q     <= '0;
                sweep_up_q <= 1'b1;
              end
              if (eff_rcnt == '0) begin
                res_status_q <= ST_EMPTY;
                state_q      <= FINISH;
              end else begin
                state_q <= SCAN;
              end
            end
          end
        end

        SCAN: begin
          // issue the next read
          if (ridx_q < rcnt_q) begin
            ridx_q <= ridx_q + CntW'(1);
            pidx_q <= ridx_q[IdxW-1:0];
            pvld_q <= 1'b1;
          end else begin
            pvld_q <= 1'b0;
          end
          // judge the entry read last cycle
          if (pvld_q) begin
            if (cmp_res.take_best) begin
              found_q    <= 1'b1;
              best_idx_q <= pidx_q;
              best_ent_q <= rdata;
            end
            if (cmp_res.take_fb) begin
              first_q  <= 1'b0;
              fb_idx_q <= pidx_q;
              fb_ent_q <= rdata;
            end
          end else if (ridx_q == rcnt_q) begin
            // scan done: grant, reverse when nothing lies ahead
            res_granted_q <= 1'b1;
            res_status_q  <= ST_OK;
            res_ent_q     <= found_q ? best_ent_q : fb_ent_q;
            if (!found_q) begin
              sweep_up_q <= ~sweep_up_q;
            end
            ridx_q  <= CntW'(pick_idx) + CntW'(1);
            state_q <= SHIFT;
          end
        end

        SHIFT: begin
          // move each later entry down by one
          if (ridx_q < rcnt_q) begin
            ridx_q <= ridx_q + CntW'(1);
            pidx_q <= ridx_q[IdxW-1:0];
            pvld_q <= 1'b1;
          end else begin
            pvld_q <= 1'b0;
          end
          if (!pvld_q && (ridx_q >= rcnt_q)) begin
            rcnt_q  <= rcnt_q - CntW'(1);
            state_q <= FINISH;
          end
        end

        FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_granted_q <= res_granted_q;
            out_ent_q     <= res_ent_q;
            out_status_q  <= res_status_q;
            out_pending_q <= (rcnt_q != '0) || (wcnt_q != '0);
            state_q       <= IDLE;
          end
        end

        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // result ports
  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_granted_q;
  assign granted_id_o    = out_ent_q[EntW-1:TRACK_BITS];
  assign granted_track_o = out_ent_q[TRACK_BITS-1:0];
  assign pending_o       = out_pending_q;
  assign status_o        = out_status_q;

  // checks
  `FSCAN_ASSERT(a_rcnt_bound, clk_i, rst_ni, rcnt_q <= CntW'(QUEUE_DEPTH))
  `FSCAN_ASSERT(a_wcnt_bound, clk_i, rst_ni, wcnt_q <= CntW'(QUEUE_DEPTH))
  `FSCAN_ASSERT(a_grant_ok, clk_i, rst_ni, out_valid_q && out_granted_q |-> out_status_q == ST_OK)
  `FSCAN_ASSERT_NEVER(a_empty_pending, clk_i, rst_ni, (out_status_q == ST_EMPTY) && out_pending_q)
  `FSCAN_ASSERT(a_scan_nonempty, clk_i, rst_ni, (state_q == SCAN) |-> (rcnt_q != '0))

endmodule
